### src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables it.
`define LEI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lei: assertion failed");

// A signal keeps its value into the next cycle whenever the condition holds.
`define LEI_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ((cond) |=> $stable(sig))) \
    else $error("lei: value changed while held");

`endif

### src/lei_pkg.sv
`timescale 1ns / 1ps

package lei_pkg;

  // Field and register widths
  localparam int unsigned COORD_BITS_DEF = 11;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned EDGE_BITS      = 20;
  localparam int unsigned ROW_BITS       = 12;
  localparam int unsigned FW_BITS        = 11;
  localparam int unsigned MID_BITS       = 12;
  localparam int unsigned OFS_BITS       = 11;
  localparam int unsigned KIND_BITS      = 2;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 12;

  // Register values after reset
  localparam logic [ROW_BITS-1:0] SCAN_ROW_RST    = 12'd119;
  localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RST = 11'd639;
  localparam logic [MID_BITS-1:0] MID_X_RST       = 12'd319;
  localparam logic [OFS_BITS-1:0] OFFSET_X_RST    = 11'd0;
  localparam logic [OFS_BITS-1:0] OFFSET_Y_RST    = 11'd119;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCAN_ROW    = 3'd0,
    CFG_FRAME_WIDTH = 3'd1,
    CFG_MID_X       = 3'd2,
    CFG_OFFSET_X    = 3'd3,
    CFG_OFFSET_Y    = 3'd4
  } cfg_idx_e;

  // What a transaction did to the edges
  typedef enum logic [KIND_BITS-1:0] {
    KIND_NONE  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2
  } kind_e;

  // Width of a coordinate once the offset has been added
  function automatic int unsigned pos_width(input int unsigned coord_bits);
    return ((coord_bits > OFS_BITS) ? coord_bits : OFS_BITS) + 1;
  endfunction

endpackage

### src/lei_xcalc.sv
`timescale 1ns / 1ps

// Crossing x at the scan row: num = xh*(row-yl) + xl*(yh-row) on one shared
// multiplier in two steps (C_MUL_A, C_MUL_B), then (num << FRAC) / dy by
// restoring division, one quotient bit per cycle.
module lei_xcalc #(
  parameter int unsigned COORD_BITS = lei_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = lei_pkg::FRAC_BITS_DEF,
  localparam int unsigned PW = lei_pkg::pos_width(COORD_BITS),
  localparam int unsigned QW = PW + FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] xh_i,
  input  logic [PW-1:0] xl_i,
  input  logic [PW-1:0] dyh_i,
  input  logic [PW-1:0] dyl_i,
  input  logic [PW-1:0] dy_i,
  output logic          done_o,
  output logic [QW-1:0] lr_o
);
  import lei_pkg::*;

  localparam int unsigned CNT_W = $clog2(QW);

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_MUL_A = 4'b0010,
    C_MUL_B = 4'b0100,
    C_DIV   = 4'b1000
  } calc_state_e;

  calc_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [2*PW-1:0]  acc_q;
  logic [PW-1:0]    rem_q;
  logic [QW-1:0]    quo_q;

  logic [PW-1:0]    op_a, op_b;
  logic [2*PW-1:0]  prod, num;
  logic [PW:0]      trial;
  logic             ge;
  logic [PW-1:0]    diff;

  // Shared multiplier operand select
  always_comb begin
    if (state_q == C_MUL_A) begin
      op_a = xh_i;
      op_b = dyl_i;
    end else begin
      op_a = xl_i;
      op_b = dyh_i;
    end
  end

  assign prod = op_a * op_b;
  // fits 2*PW bits: the crossing lies below 2^PW
  assign num  = acc_q + prod;

  // One restoring division step
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, dy_i};
  assign diff  = trial[PW-1:0] - dy_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:  if (start_i) state_d = C_MUL_A;
      C_MUL_A: state_d = C_MUL_B;
      C_MUL_B: state_d = C_DIV;
      C_DIV:   if (cnt_q == '0) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_DIV) && (cnt_q == '0);
      if (state_q == C_MUL_B) begin
        cnt_q <= CNT_W'(QW - 1);
      end else if (state_q == C_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath: accumulator, partial remainder, dividend/quotient shifter
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_MUL_A: acc_q <= prod;
      C_MUL_B: begin
        rem_q <= num[2*PW-1:PW];
        quo_q <= QW'(num[PW-1:0]) << FRAC_BITS;
      end
      C_DIV: begin
        rem_q <= ge ? diff : trial[PW-1:0];
        quo_q <= {quo_q[QW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign lr_o   = quo_q;

endmodule

### src/lane_edge_intersection_tracker.sv
`timescale 1ns / 1ps

// Lane edge tracker. Each input transaction carries one line segment and a
// start_frame flag; each yields exactly one output transaction holding the
// left and right lane edges (unsigned, FRAC_BITS fraction bits) and the kind
// of update made. Both channels use valid/stall; a transaction moves on a
// rising edge with valid high and stall low.
// Registers are written through the cfg port (index, data, valid/ready,
// ready always high). The user must write them only while the block is
// idle; the block itself does not enforce this.
// A segment that straddles the scan row goes from S_PREP through the
// crossing unit (two multiply steps, then QW divide steps; QW = PW +
// FRAC_BITS with PW = max(COORD_BITS, OFS_BITS) + 1, 20 at the defaults)
// to S_FIN; any other segment goes from S_PREP straight to S_FIN. One
// segment is in work at a time; in_stall_o is high from acceptance until
// the result enters the output register. A stalled output holds; the
// finished result waits inside until the output register frees, and no
// new segment is taken while it waits.
// Reset clears both edges to zero and loads the register defaults.
module lane_edge_intersection_tracker #(
  parameter int unsigned COORD_BITS = lei_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = lei_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lei_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lei_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [COORD_BITS-1:0]            seg_ax_i,
  input  logic [COORD_BITS-1:0]            seg_ay_i,
  input  logic [COORD_BITS-1:0]            seg_bx_i,
  input  logic [COORD_BITS-1:0]            seg_by_i,
  input  logic                             start_frame_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lei_pkg::EDGE_BITS-1:0]    left_edge_x_o,
  output logic [lei_pkg::EDGE_BITS-1:0]    right_edge_x_o,
  output logic [lei_pkg::KIND_BITS-1:0]    update_kind_o
);
  import lei_pkg::*;

  localparam int unsigned PW = pos_width(COORD_BITS);
  localparam int unsigned QW = PW + FRAC_BITS;
  localparam int unsigned SW = FW_BITS + 1 + FRAC_BITS;
  localparam int unsigned CW = (QW > EDGE_BITS) ? QW : EDGE_BITS;
  localparam int unsigned RW = PW + 2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_CALC = 4'b0100,
    S_FIN  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;

  // Configuration registers
  logic [ROW_BITS-1:0] scan_row_q;
  logic [FW_BITS-1:0]  frame_width_q;
  logic [MID_BITS-1:0] mid_x_q;
  logic [OFS_BITS-1:0] offset_x_q;
  logic [OFS_BITS-1:0] offset_y_q;

  // Edge state and output register
  logic [EDGE_BITS-1:0] left_q, right_q;
  logic                 out_valid_q;
  logic [EDGE_BITS-1:0] out_left_q, out_right_q;
  kind_e                out_kind_q;

  // Per-segment working registers
  logic [PW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [PW-1:0] xh_q, xl_q, dyh_q, dyl_q, dy_q;
  logic          go_left_q, cross_q;

  logic          accept, out_free;
  logic          calc_start, calc_done;
  logic [QW-1:0] calc_lr;

  // Sort and classify signals
  logic          b_high, straddle, rising, steep, lzone, rzone, go_left;
  logic [PW-1:0] xh, xl, yh, yl, row_ext, adx, half_ext;
  logic [RW-1:0] mid3;

  // Bound and update signals
  logic [FW_BITS:0]     right_sum;
  logic [CW-1:0]        lr_w, lbound, rbound;
  logic                 raise, lower;
  logic [EDGE_BITS-1:0] new_left, new_right;
  kind_e                new_kind;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Order endpoints by y and classify the segment
  always_comb begin
    b_high   = by_q > ay_q;
    xh       = b_high ? bx_q : ax_q;
    yh       = b_high ? by_q : ay_q;
    xl       = b_high ? ax_q : bx_q;
    yl       = b_high ? ay_q : by_q;
    row_ext  = PW'(scan_row_q);
    straddle = (yh > row_ext) && (yl < row_ext);
    rising   = xh >= xl;
    adx      = rising ? (xh - xl) : (xl - xh);
    // vertical counts as steep rising: dy > 0 = 2*|dx|
    steep    = {1'b0, yh - yl} > {adx, 1'b0};
    half_ext = PW'(mid_x_q >> 1);
    lzone    = (xh < half_ext) && (xl < half_ext);
    mid3     = RW'(mid_x_q) + (RW'(mid_x_q) << 1);
    rzone    = ((RW'(xh) << 1) > mid3) && ((RW'(xl) << 1) > mid3);
    // in the middle zone, rising-steep and falling-shallow both go left
    go_left  = lzone || (!rzone && (rising == steep));
  end

  // Frame bounds and the edge update
  always_comb begin
    right_sum = {1'b0, frame_width_q} + {1'b0, offset_x_q};
    lr_w      = CW'(calc_lr);
    lbound    = CW'(SW'(offset_x_q) << FRAC_BITS);
    rbound    = CW'(SW'(right_sum) << FRAC_BITS);
    raise     = cross_q && go_left_q && (lr_w > lbound) && (lr_w > CW'(left_q));
    lower     = cross_q && !go_left_q && (lr_w < rbound) && (lr_w < CW'(right_q));
    new_left  = raise ? EDGE_BITS'(calc_lr) : left_q;
    new_right = lower ? EDGE_BITS'(calc_lr) : right_q;
    if (raise) begin
      new_kind = KIND_LEFT;
    end else if (lower) begin
      new_kind = KIND_RIGHT;
    end else begin
      new_kind = KIND_NONE;
    end
  end

  assign calc_start = (state_q == S_PREP) && straddle;

  // Main sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PREP;
      S_PREP: state_d = straddle ? S_CALC : S_FIN;
      S_CALC: if (calc_done) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, registers and edges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      left_q        <= '0;
      right_q       <= '0;
      scan_row_q    <= SCAN_ROW_RST;
      frame_width_q <= FRAME_WIDTH_RST;
      mid_x_q       <= MID_X_RST;
      offset_x_q    <= OFFSET_X_RST;
      offset_y_q    <= OFFSET_Y_RST;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SCAN_ROW:    scan_row_q    <= cfg_data_i[ROW_BITS-1:0];
          CFG_FRAME_WIDTH: frame_width_q <= cfg_data_i[FW_BITS-1:0];
          CFG_MID_X:       mid_x_q       <= cfg_data_i[MID_BITS-1:0];
          CFG_OFFSET_X:    offset_x_q    <= cfg_data_i[OFS_BITS-1:0];
          CFG_OFFSET_Y:    offset_y_q    <= cfg_data_i[OFS_BITS-1:0];
          default: ;
        endcase
      end

      // start of frame reloads both edges before this segment is judged
      if (accept && start_frame_i) begin
        left_q  <= EDGE_BITS'(lbound);
        right_q <= EDGE_BITS'(rbound);
      end else if ((state_q == S_FIN) && out_free) begin
        left_q  <= new_left;
        right_q <= new_right;
      end

      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q <= PW'(seg_ax_i) + PW'(offset_x_q);
      ay_q <= PW'(seg_ay_i) + PW'(offset_y_q);
      bx_q <= PW'(seg_bx_i) + PW'(offset_x_q);
      by_q <= PW'(seg_by_i) + PW'(offset_y_q);
    end
    if (state_q == S_PREP) begin
      xh_q      <= xh;
      xl_q      <= xl;
      dyh_q     <= yh - row_ext;
      dyl_q     <= row_ext - yl;
      dy_q      <= yh - yl;
      go_left_q <= go_left;
      cross_q   <= straddle;
    end
    if ((state_q == S_FIN) && out_free) begin
      out_left_q  <= new_left;
      out_right_q <= new_right;
      out_kind_q  <= new_kind;
    end
  end

  lei_xcalc #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_xcalc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(calc_start),
    .xh_i   (xh_q),
    .xl_i   (xl_q),
    .dyh_i  (dyh_q),
    .dyl_i  (dyl_q),
    .dy_i   (dy_q),
    .done_o (calc_done),
    .lr_o   (calc_lr)
  );

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign left_edge_x_o  = out_left_q;
  assign right_edge_x_o = out_right_q;
  assign update_kind_o  = out_kind_q;

endmodule

### src/lei_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the tracker
module lei_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lei_pkg::EDGE_BITS-1:0] left_edge_x_o,
  input logic [lei_pkg::EDGE_BITS-1:0] right_edge_x_o,
  input logic [lei_pkg::KIND_BITS-1:0] update_kind_o
);
  import lei_pkg::*;

  logic [2*EDGE_BITS+KIND_BITS-1:0] out_payload;
  logic                             in_xact;
  logic                             out_held;

  assign out_payload = {left_edge_x_o, right_edge_x_o, update_kind_o};
  assign in_xact     = in_valid_i && !in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;

  // a stalled result stays offered and unchanged
  `LEI_ASSERT(a_out_valid_held, clk_i, rst_ni, out_held |=> out_valid_o)
  `LEI_ASSERT_HOLD(a_out_payload_held, clk_i, rst_ni, out_held, out_payload)

  // the block is busy right after taking a segment
  `LEI_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_xact |=> in_stall_o)

  // a new result only comes out of a busy cycle
  `LEI_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))

endmodule

bind lane_edge_intersection_tracker lei_checker u_lei_checker (.*);
